// ----- design/fapid_pkg.sv -----
// ---------------------------------------------------------------------------
// fapid_pkg
// Shared types, constants and the atan table for the four-axis PID block.
// ---------------------------------------------------------------------------
`default_nettype none
package fapid_pkg;

  localparam int AxisCount   = 4;
  localparam int CordicSteps = 16;
  localparam int AxisW       = 2;
  localparam int StepW       = 5;

  localparam logic [17:0] DtFirst = 18'd20972;
  localparam logic [17:0] DtMin   = 18'd1049;
  localparam logic [17:0] DtMax   = 18'd209715;
  localparam logic signed [22:0] PiQ13    = 23'sd25736;
  localparam logic signed [22:0] TwoPiQ13 = 23'sd51472;
  localparam logic signed [24:0] PiQ20    = 25'sd3294199;

  localparam logic [2:0] CfgGainsH = 3'd0;
  localparam logic [2:0] CfgGainsV = 3'd1;
  localparam logic [2:0] CfgGainsY = 3'd2;
  localparam logic [2:0] CfgIlim   = 3'd3;
  localparam logic [2:0] CfgClim   = 3'd4;

  localparam logic [AxisW-1:0] AxisYaw = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_CORDIC, ST_WRAP, ST_INC, ST_INTEG, ST_MULP,
    ST_MULD, ST_MULI, ST_SUM, ST_DONE
  } state_t;

  function automatic logic signed [24:0] atan_q20(input logic [StepW-1:0] i);
    case (i)
      5'd0: atan_q20 = 25'sd823550;
      5'd1: atan_q20 = 25'sd486170;
      5'd2: atan_q20 = 25'sd256879;
      5'd3: atan_q20 = 25'sd130396;
      5'd4: atan_q20 = 25'sd65451;
      5'd5: atan_q20 = 25'sd32757;
      5'd6: atan_q20 = 25'sd16383;
      5'd7: atan_q20 = 25'sd8192;
      5'd8: atan_q20 = 25'sd4096;
      5'd9: atan_q20 = 25'sd2048;
      5'd10: atan_q20 = 25'sd1024;
      5'd11: atan_q20 = 25'sd512;
      5'd12: atan_q20 = 25'sd256;
      5'd13: atan_q20 = 25'sd128;
      5'd14: atan_q20 = 25'sd64;
      5'd15: atan_q20 = 25'sd32;
      5'd16: atan_q20 = 25'sd16;
      5'd17: atan_q20 = 25'sd8;
      5'd18: atan_q20 = 25'sd4;
      5'd19: atan_q20 = 25'sd2;
      5'd20: atan_q20 = 25'sd1;
      default: atan_q20 = 25'sd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- design/fapid_cordic.sv -----
// ---------------------------------------------------------------------------
// fapid_cordic
// Vectoring CORDIC atan2, one iteration per cycle, result in Q13.
// ---------------------------------------------------------------------------
`default_nettype none
module fapid_cordic (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [34:0] y_in,
  input  wire logic signed [34:0] x_in,
  output logic                    done,
  output logic signed [22:0]      angle
);

  logic signed [36:0] x, y;
  logic signed [25:0] z;
  logic [fapid_pkg::StepW-1:0] step;
  logic busy;
  logic signed [25:0] zr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == fapid_pkg::StepW'(fapid_pkg::CordicSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (x_in < 0) begin
        x <= -37'(x_in);
        y <= -37'(y_in);
        z <= (y_in >= 0) ? 26'(fapid_pkg::PiQ20) : -26'(fapid_pkg::PiQ20);
      end else begin
        x <= 37'(x_in);
        y <= 37'(y_in);
        z <= '0;
      end
    end else if (busy) begin
      if (y > 0) begin
        x <= x + (y >>> step);
        y <= y - (x >>> step);
        z <= z + 26'(fapid_pkg::atan_q20(step));
      end else begin
        x <= x - (y >>> step);
        y <= y + (x >>> step);
        z <= z - 26'(fapid_pkg::atan_q20(step));
      end
    end
  end

  assign zr    = z + 26'sd64;
  assign angle = 23'(zr >>> 7);

endmodule
`default_nettype wire

// ----- design/fapid_core.sv -----
// ---------------------------------------------------------------------------
// fapid_core
// Sequencer around one shared signed multiplier, integrators and clamps.
// ---------------------------------------------------------------------------
`default_nettype none
module fapid_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [1:0]  func,
  input  wire logic signed [19:0] setpoint,
  input  wire logic signed [19:0] measured_position,
  input  wire logic signed [19:0] measured_rate,
  input  wire logic signed [15:0] qw, qx, qy, qz,
  input  wire logic [17:0] elapsed_time,
  input  wire logic [47:0] gains,
  input  wire logic [15:0] ilim,
  input  wire logic [15:0] clim,
  output logic             busy,
  output logic             done,
  output logic signed [15:0] command
);

  fapid_pkg::state_t state, state_next;
  logic signed [39:0] integ [fapid_pkg::AxisCount];
  logic [fapid_pkg::AxisCount-1:0] seen;
  logic [1:0] ax;
  logic yaw;
  logic signed [19:0] sp, rt;
  logic signed [15:0] w, x, y, z;
  logic [17:0] dt;
  logic [2:0] pstep;
  logic signed [34:0] siny, cosy;
  logic signed [22:0] e;
  logic signed [39:0] inew;
  logic signed [63:0] acc;
  logic signed [63:0] pd;

  // shared multiplier
  logic signed [40:0] ma;
  logic signed [24:0] mb;
  logic signed [63:0] prod;
  assign prod = 64'(ma) * 64'(mb);

  logic cstart, cdone;
  logic signed [22:0] yawq;
  fapid_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cstart),
    .y_in(siny), .x_in(cosy), .done(cdone), .angle(yawq)
  );

  always_comb begin
    state_next = state;
    case (state)
      fapid_pkg::ST_IDLE:   if (start) state_next = fapid_pkg::ST_PREP;
      fapid_pkg::ST_PREP: begin
        if (!yaw) state_next = fapid_pkg::ST_INC;
        else if (pstep == 3'd4) state_next = fapid_pkg::ST_CORDIC;
      end
      fapid_pkg::ST_CORDIC: if (cdone) state_next = fapid_pkg::ST_WRAP;
      fapid_pkg::ST_WRAP: begin
        if (e <= fapid_pkg::PiQ13 && e >= -fapid_pkg::PiQ13)
          state_next = fapid_pkg::ST_INC;
      end
      fapid_pkg::ST_INC:    state_next = fapid_pkg::ST_INTEG;
      fapid_pkg::ST_INTEG:  state_next = fapid_pkg::ST_MULP;
      fapid_pkg::ST_MULP:   state_next = fapid_pkg::ST_MULD;
      fapid_pkg::ST_MULD:   state_next = fapid_pkg::ST_MULI;
      fapid_pkg::ST_MULI:   state_next = fapid_pkg::ST_SUM;
      fapid_pkg::ST_SUM:    state_next = fapid_pkg::ST_DONE;
      fapid_pkg::ST_DONE:   state_next = fapid_pkg::ST_IDLE;
      default:              state_next = fapid_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    cstart = 1'b0;
    case (state)
      fapid_pkg::ST_PREP: begin
        case (pstep)
          3'd0: begin ma = 41'(w); mb = 25'(z); end
          3'd1: begin ma = 41'(x); mb = 25'(y); end
          3'd2: begin ma = 41'(y); mb = 25'(y); end
          3'd3: begin ma = 41'(z); mb = 25'(z); end
          default: cstart = 1'b1;
        endcase
      end
      fapid_pkg::ST_INC:  begin ma = 41'(e); mb = 25'($signed({1'b0, dt})); end
      fapid_pkg::ST_MULP: begin ma = 41'(e); mb = 25'($signed({1'b0, gains[15:0]})); end
      fapid_pkg::ST_MULD: begin ma = 41'(rt); mb = 25'($signed({1'b0, gains[47:32]})); end
      fapid_pkg::ST_MULI: begin
        ma = 41'(integ[ax]); mb = 25'($signed({1'b0, gains[31:16]}));
      end
      default: ;
    endcase
  end

  assign busy = (state != fapid_pkg::ST_IDLE);
  assign done = (state == fapid_pkg::ST_DONE);

  logic signed [40:0] lim;
  logic signed [40:0] isum;
  logic signed [63:0] rnd;
  logic signed [63:0] cmd64;
  logic signed [16:0] cl;
  assign lim = $signed({1'b0, ilim, 24'd0}) >>> 8;

  always_comb begin
    rnd = yaw ? (acc + 64'sd16384) >>> 15 : (acc + 64'sd134217728) >>> 28;
    cmd64 = rnd;
    if (cmd64 > 64'($signed({1'b0, clim}))) cmd64 = 64'($signed({1'b0, clim}));
    if (cmd64 < -64'($signed({1'b0, clim}))) cmd64 = -64'($signed({1'b0, clim}));
    cl = 17'(cmd64);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fapid_pkg::ST_IDLE;
      seen  <= '0;
      for (int i = 0; i < fapid_pkg::AxisCount; i++) integ[i] <= '0;
    end else begin
      state <= state_next;
      if (state == fapid_pkg::ST_MULP) begin
        integ[ax] <= inew;
        seen[ax]  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      fapid_pkg::ST_IDLE: if (start) begin
        ax <= func; yaw <= (func == fapid_pkg::AxisYaw);
        sp <= setpoint; rt <= measured_rate;
        w <= qw; x <= qx; y <= qy; z <= qz;
        pstep <= '0;
        if (!seen[func]) dt <= fapid_pkg::DtFirst;
        else if (elapsed_time < fapid_pkg::DtMin) dt <= fapid_pkg::DtMin;
        else if (elapsed_time > fapid_pkg::DtMax) dt <= fapid_pkg::DtMax;
        else dt <= elapsed_time;
        e <= 23'(setpoint) - 23'(measured_position);
        siny <= '0;
        cosy <= 35'sd268435456;
      end
      fapid_pkg::ST_PREP: begin
        pstep <= pstep + 1'b1;
        case (pstep)
          3'd0, 3'd1: siny <= siny + 35'(prod <<< 1);
          3'd2, 3'd3: cosy <= cosy - 35'(prod <<< 1);
          default: ;
        endcase
      end
      fapid_pkg::ST_CORDIC: if (cdone) e <= 23'(sp) - yawq;
      fapid_pkg::ST_WRAP: begin
        if (e > fapid_pkg::PiQ13) e <= e - fapid_pkg::TwoPiQ13;
        else if (e < -fapid_pkg::PiQ13) e <= e + fapid_pkg::TwoPiQ13;
      end
      fapid_pkg::ST_INC: begin
        if (yaw) isum <= 41'(integ[ax]) + 41'((prod + 64'sd4096) >>> 13);
        else     isum <= 41'(integ[ax]) + 41'(prod);
      end
      fapid_pkg::ST_INTEG: begin
        if (isum > lim) inew <= 40'(lim);
        else if (isum < -lim) inew <= 40'(-lim);
        else inew <= 40'(isum);
      end
      fapid_pkg::ST_MULP: pd <= prod;
      fapid_pkg::ST_MULD: pd <= pd - prod;
      fapid_pkg::ST_MULI: acc <= yaw ? (pd <<< 7) + prod : (pd <<< 20) + prod;
      fapid_pkg::ST_SUM: begin
        if (cl > 17'sd32767) command <= 16'sd32767;
        else if (cl < -17'sd32768) command <= -16'sd32768;
        else command <= 16'(cl);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/four_axis_pid_position_control.sv -----
// ---------------------------------------------------------------------------
// four_axis_pid_position_control
// Four-axis PID controller, one item at a time through a shared multiplier.
// Linear axes go straight to the PID steps; yaw first runs 16 CORDIC steps and
// then wraps the heading error by 2*pi into [-pi, pi], at most 11 times.
// tready stays low from acceptance until the result is taken. Reset: sync active
// high; integrators, flags and gains clear, limits reset to all ones.
// ---------------------------------------------------------------------------
`default_nettype none
module four_axis_pid_position_control (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // setpoint, measured_position, measured_rate, quat_w..z, elapsed_time
  input  wire logic [143:0] s_axis_tdata,
  // func
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // command
  output logic [15:0]       m_axis_tdata,
  // axis
  output logic [1:0]        m_axis_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [47:0]  cfg_data
);

  logic [47:0] g_h, g_v, g_y, ilims, clims;
  logic [1:0] func;
  logic grp_h, grp_v, start, busy, done, pend, inrange;
  logic [1:0] fr;
  logic signed [15:0] cmd;

  assign cfg_ready = 1'b1;
  assign func = s_axis_tuser;
  assign s_axis_tready = !busy && !pend;
  assign start = s_axis_tvalid && s_axis_tready && inrange;
  assign inrange = (32'(func) < fapid_pkg::AxisCount);

  always_ff @(posedge clk) begin
    if (rst) begin
      g_h <= '0; g_v <= '0; g_y <= '0; ilims <= '1; clims <= '1;
    end else if (cfg_valid) begin
      case (cfg_index)
        fapid_pkg::CfgGainsH: g_h <= cfg_data;
        fapid_pkg::CfgGainsV: g_v <= cfg_data;
        fapid_pkg::CfgGainsY: g_y <= cfg_data;
        fapid_pkg::CfgIlim:   ilims <= cfg_data;
        fapid_pkg::CfgClim:   clims <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) fr <= '0;
    else if (s_axis_tvalid && s_axis_tready) fr <= func;
  end

  assign grp_h = (busy ? fr : func) < 2'd2;
  assign grp_v = (busy ? fr : func) == 2'd2;

  fapid_core u_core (
    .clk(clk), .rst(rst), .start(start), .func(func),
    .setpoint(s_axis_tdata[19:0]), .measured_position(s_axis_tdata[39:20]),
    .measured_rate(s_axis_tdata[59:40]),
    .qw(s_axis_tdata[75:60]), .qx(s_axis_tdata[91:76]),
    .qy(s_axis_tdata[107:92]), .qz(s_axis_tdata[123:108]),
    .elapsed_time(s_axis_tdata[141:124]),
    .gains(grp_h ? g_h : (grp_v ? g_v : g_y)),
    .ilim(grp_h ? ilims[15:0] : (grp_v ? ilims[31:16] : ilims[47:32])),
    .clim(grp_h ? clims[15:0] : (grp_v ? clims[31:16] : clims[47:32])),
    .busy(busy), .done(done), .command(cmd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      pend <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) pend <= 1'b1;
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
        pend <= 1'b0;
      end
      if (done || (s_axis_tvalid && s_axis_tready && !inrange)) m_axis_tvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_axis_tdata <= cmd;
      m_axis_tuser <= fr;
    end else if (s_axis_tvalid && s_axis_tready && !inrange) begin
      m_axis_tdata <= '0;
      m_axis_tuser <= func;
    end
  end

endmodule
`default_nettype wire

// ----- design/fapid_checker.sv -----
// ---------------------------------------------------------------------------
// fapid_checker
// Port-level checks for the four-axis PID block.
// ---------------------------------------------------------------------------
`default_nettype none
module fapid_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("ready after request");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped");

endmodule

bind four_axis_pid_position_control fapid_checker u_fapid_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
